### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a condition at every clock edge
`define ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// check that a trigger is followed by a condition in the next cycle
`define ASSERT_NEXT(name, trig, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

### sv/tbss_pkg.sv
// ----------------------------------------------------------------------------
// tbss_pkg
// Types, constants and helpers for the text byte stream statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package tbss_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int TALLY_COUNT = 10;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
  localparam int RESQ_DEPTH = 2;
  localparam int RESQ_AW    = $clog2(RESQ_DEPTH);
  localparam int RESQ_CW    = $clog2(RESQ_DEPTH + 1);

  localparam int T_LINES = 0;
  localparam int T_SPACE = 1;
  localparam int T_TAB   = 2;
  localparam int T_PLAIN = 3;
  localparam int T_MIXED = 4;
  localparam int T_DOS   = 5;
  localparam int T_UNIX  = 6;
  localparam int T_MALF  = 7;
  localparam int T_ANSI  = 8;
  localparam int T_UTF8  = 9;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] total_lines;
    logic [31:0] space_only_lines;
    logic [31:0] tab_only_lines;
    logic [31:0] plain_lines;
    logic [31:0] mixed_lines;
    logic [31:0] dos_endings;
    logic [31:0] unix_endings;
    logic [31:0] malformed_endings;
    logic [31:0] ansi_bytes;
    logic [31:0] utf8_chars;
  } result_t;

  typedef struct packed {
    logic       inc_lines;
    logic       inc_space;
    logic       inc_tab;
    logic       inc_plain;
    logic       inc_mixed;
    logic       inc_dos;
    logic       inc_unix;
    logic       malformed;
    logic [1:0] ansi_amount;
    logic       inc_utf8;
    logic       last;
  } cmd_t;

  function automatic count_t sat_add(input count_t c, input logic [1:0] amount);
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, c} + (COUNT_WIDTH + 1)'(amount);
    return s[COUNT_WIDTH] ? CNT_MAX : s[COUNT_WIDTH-1:0];
  endfunction

  function automatic logic [31:0] clamp32(input count_t c);
    logic [63:0] w;
    w = 64'(c);
    return (w > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

endpackage

`default_nettype wire

### sv/tbss_front.sv
// ----------------------------------------------------------------------------
// tbss_front
// Classifies each byte against the line and UTF-8 trackers and issues one
// counter update command per accepted beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tbss_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire tbss_pkg::in_item_t item,
  input  wire logic              cmdq_full,
  output tbss_pkg::cmd_t         cmd,
  output logic                   cmd_push
);
  import tbss_pkg::*;

  logic       at_line_start, at_line_start_next;
  logic       space_seen,    space_seen_next;
  logic       tab_seen,      tab_seen_next;
  logic       after_cr,      after_cr_next;
  logic       after_bare_lf, after_bare_lf_next;
  logic [2:0] utf8_expected, utf8_expected_next;
  logic [2:0] utf8_received, utf8_received_next;

  logic [7:0] b;
  logic [2:0] rec_inc;

  assign cmd_push = push && !cmdq_full;
  assign b        = item.byte_value;
  assign rec_inc  = utf8_received + 3'd1;

  always_comb begin
    cmd                = '0;
    cmd.last           = item.last_byte;
    at_line_start_next = at_line_start;
    space_seen_next    = space_seen;
    tab_seen_next      = tab_seen;
    after_cr_next      = after_cr;
    after_bare_lf_next = after_bare_lf;
    utf8_expected_next = utf8_expected;
    utf8_received_next = utf8_received;

    if (b == CH_TAB || b == CH_SPACE) begin
      if (at_line_start) begin
        if (b == CH_TAB) tab_seen_next = 1'b1;
        else space_seen_next = 1'b1;
      end
      after_cr_next      = 1'b0;
      after_bare_lf_next = 1'b0;
    end else if (b == CH_LF) begin
      if (after_cr) begin
        cmd.inc_dos = 1'b1;
      end else begin
        cmd.inc_unix       = 1'b1;
        after_bare_lf_next = 1'b1;
      end
      cmd.inc_lines = 1'b1;
      cmd.inc_mixed = tab_seen && space_seen;
      cmd.inc_tab   = tab_seen && !space_seen;
      cmd.inc_space = !tab_seen && space_seen;
      cmd.inc_plain = !tab_seen && !space_seen;
      tab_seen_next      = 1'b0;
      space_seen_next    = 1'b0;
      at_line_start_next = 1'b1;
      after_cr_next      = 1'b0;
    end else if (b == CH_CR) begin
      if (after_bare_lf) begin
        cmd.malformed = 1'b1;
        after_cr_next = 1'b0;
      end else begin
        after_cr_next = 1'b1;
      end
      after_bare_lf_next = 1'b0;
    end else begin
      at_line_start_next = 1'b0;
      after_cr_next      = 1'b0;
      after_bare_lf_next = 1'b0;
      if (b[7]) begin
        if (utf8_expected != 3'd0) begin
          if ((b & CONT_MASK) == CONT_CODE) begin
            if (rec_inc >= utf8_expected) begin
              cmd.inc_utf8       = 1'b1;
              utf8_expected_next = 3'd0;
              utf8_received_next = 3'd0;
            end else begin
              utf8_received_next = rec_inc;
            end
          end else begin
            cmd.ansi_amount    = utf8_received[1:0];
            utf8_expected_next = 3'd0;
            utf8_received_next = 3'd0;
          end
        end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
          utf8_expected_next = 3'd2;
          utf8_received_next = 3'd1;
        end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
          utf8_expected_next = 3'd3;
          utf8_received_next = 3'd1;
        end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
          utf8_expected_next = 3'd4;
          utf8_received_next = 3'd1;
        end else begin
          cmd.ansi_amount = 2'd1;
        end
      end
    end

    // drop all line and sequence state after the final byte
    if (item.last_byte) begin
      at_line_start_next = 1'b1;
      space_seen_next    = 1'b0;
      tab_seen_next      = 1'b0;
      after_cr_next      = 1'b0;
      after_bare_lf_next = 1'b0;
      utf8_expected_next = 3'd0;
      utf8_received_next = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_line_start <= 1'b1;
      space_seen    <= 1'b0;
      tab_seen      <= 1'b0;
      after_cr      <= 1'b0;
      after_bare_lf <= 1'b0;
      utf8_expected <= 3'd0;
      utf8_received <= 3'd0;
    end else if (cmd_push) begin
      at_line_start <= at_line_start_next;
      space_seen    <= space_seen_next;
      tab_seen      <= tab_seen_next;
      after_cr      <= after_cr_next;
      after_bare_lf <= after_bare_lf_next;
      utf8_expected <= utf8_expected_next;
      utf8_received <= utf8_received_next;
    end
  end

endmodule

`default_nettype wire

### sv/tbss_cmd_queue.sv
// ----------------------------------------------------------------------------
// tbss_cmd_queue
// Short command queue between the classifier and the counter bank.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tbss_cmd_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire tbss_pkg::cmd_t din,
  output logic                full,
  output logic                empty,
  input  wire logic           pop,
  output tbss_pkg::cmd_t      dout
);
  import tbss_pkg::*;

  cmd_t               mem [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr;
  logic [CMDQ_AW-1:0] rd_ptr;
  logic [CMDQ_CW-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == CMDQ_CW'(CMDQ_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + CMDQ_AW'(1);
      if (do_pop) rd_ptr <= rd_ptr + CMDQ_AW'(1);
      if (do_push && !do_pop) count <= count + CMDQ_CW'(1);
      else if (do_pop && !do_push) count <= count - CMDQ_CW'(1);
    end
  end

  `ASSERT_ALWAYS(a_count_bound, count <= CMDQ_CW'(CMDQ_DEPTH), "command queue overfilled")
  `ASSERT_NEXT(a_count_up, do_push && !do_pop, count == $past(count) + CMDQ_CW'(1),
    "command queue count missed a push")
  `ASSERT_NEXT(a_count_down, do_pop && !do_push, count == $past(count) - CMDQ_CW'(1),
    "command queue count missed a pop")

endmodule

`default_nettype wire

### sv/tbss_back.sv
// ----------------------------------------------------------------------------
// tbss_back
// Saturating counter bank; applies commands and queues the totals on the
// final byte of a file.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tbss_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmdq_empty,
  input  wire tbss_pkg::cmd_t  cmd,
  output logic                 cmdq_pop,
  output logic                 empty,
  input  wire logic            pop,
  output tbss_pkg::result_t    result
);
  import tbss_pkg::*;

  count_t             tally     [TALLY_COUNT];
  count_t             tally_upd [TALLY_COUNT];
  logic [1:0]         amount    [TALLY_COUNT];
  result_t            res_new;
  result_t            rmem      [RESQ_DEPTH];
  logic [RESQ_AW-1:0] rwr_ptr;
  logic [RESQ_AW-1:0] rrd_ptr;
  logic [RESQ_CW-1:0] rcount;
  logic               rfull;
  logic               emit;
  logic               do_rpop;

  assign rfull    = (rcount == RESQ_CW'(RESQ_DEPTH));
  assign empty    = (rcount == '0);
  assign do_rpop  = pop && !empty;
  assign cmdq_pop = !cmdq_empty && (!cmd.last || !rfull);
  assign emit     = cmdq_pop && cmd.last;
  assign result   = rmem[rrd_ptr];

  always_comb begin
    amount[T_LINES] = {1'b0, cmd.inc_lines};
    amount[T_SPACE] = {1'b0, cmd.inc_space};
    amount[T_TAB]   = {1'b0, cmd.inc_tab};
    amount[T_PLAIN] = {1'b0, cmd.inc_plain};
    amount[T_MIXED] = {1'b0, cmd.inc_mixed};
    amount[T_DOS]   = {1'b0, cmd.inc_dos};
    amount[T_UNIX]  = {1'b0, cmd.inc_unix};
    amount[T_MALF]  = {1'b0, cmd.malformed};
    amount[T_ANSI]  = cmd.ansi_amount;
    amount[T_UTF8]  = {1'b0, cmd.inc_utf8};
    for (int k = 0; k < TALLY_COUNT; k++) begin
      tally_upd[k] = sat_add(tally[k], amount[k]);
    end
    // reclassify the last bare line feed
    if (cmd.malformed && tally[T_UNIX] != '0) begin
      tally_upd[T_UNIX] = tally[T_UNIX] - count_t'(1);
    end
  end

  always_comb begin
    res_new.total_lines       = clamp32(tally_upd[T_LINES]);
    res_new.space_only_lines  = clamp32(tally_upd[T_SPACE]);
    res_new.tab_only_lines    = clamp32(tally_upd[T_TAB]);
    res_new.plain_lines       = clamp32(tally_upd[T_PLAIN]);
    res_new.mixed_lines       = clamp32(tally_upd[T_MIXED]);
    res_new.dos_endings       = clamp32(tally_upd[T_DOS]);
    res_new.unix_endings      = clamp32(tally_upd[T_UNIX]);
    res_new.malformed_endings = clamp32(tally_upd[T_MALF]);
    res_new.ansi_bytes        = clamp32(tally_upd[T_ANSI]);
    res_new.utf8_chars        = clamp32(tally_upd[T_UTF8]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TALLY_COUNT; k++) tally[k] <= '0;
    end else if (emit) begin
      for (int k = 0; k < TALLY_COUNT; k++) tally[k] <= '0;
    end else if (cmdq_pop) begin
      for (int k = 0; k < TALLY_COUNT; k++) tally[k] <= tally_upd[k];
    end
  end

  always_ff @(posedge clk) begin
    if (emit) rmem[rwr_ptr] <= res_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rwr_ptr <= '0;
      rrd_ptr <= '0;
      rcount  <= '0;
    end else begin
      if (emit) rwr_ptr <= rwr_ptr + RESQ_AW'(1);
      if (do_rpop) rrd_ptr <= rrd_ptr + RESQ_AW'(1);
      if (emit && !do_rpop) rcount <= rcount + RESQ_CW'(1);
      else if (do_rpop && !emit) rcount <= rcount - RESQ_CW'(1);
    end
  end

  `ASSERT_ALWAYS(a_res_bound, rcount <= RESQ_CW'(RESQ_DEPTH), "result queue overfilled")
  `ASSERT_NEXT(a_clear_on_emit, emit, tally[T_LINES] == '0 && tally[T_ANSI] == '0,
    "counters not cleared after totals")
  `ASSERT_NEXT(a_emit_lands, emit && !do_rpop, rcount == $past(rcount) + RESQ_CW'(1),
    "totals beat lost")

endmodule

`default_nettype wire

### sv/text_byte_stream_statistics.sv
// ----------------------------------------------------------------------------
// text_byte_stream_statistics
// Line ending, leading whitespace and UTF-8 statistics over a byte stream.
// ----------------------------------------------------------------------------
// One file byte is taken per beat, one per clock cycle when the result side
// keeps up. Each byte is classified in the cycle it is accepted and leaves a
// counter update in a four-entry command queue; the counter bank retires one
// update per cycle unless held at a last byte. On the byte marked last, the
// ten totals (saturating, shown as 32 bits) enter the result queue as that
// byte's update leaves the command queue; every counter and flag starts over
// for the next file. Up to two sets of totals wait in the result queue; while
// it is full the counter bank holds at the next last byte and input fills up.
`default_nettype none

module text_byte_stream_statistics (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire tbss_pkg::in_item_t item,
  output logic                    empty,
  input  wire logic               pop,
  output tbss_pkg::result_t       result
);
  import tbss_pkg::*;

  cmd_t cmd_in;
  cmd_t cmd_out;
  logic cmd_push;
  logic cmdq_empty;
  logic cmdq_pop;

  tbss_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .cmdq_full (full),
    .cmd       (cmd_in),
    .cmd_push  (cmd_push)
  );

  tbss_cmd_queue u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (full),
    .empty (cmdq_empty),
    .pop   (cmdq_pop),
    .dout  (cmd_out)
  );

  tbss_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmdq_empty (cmdq_empty),
    .cmd        (cmd_out),
    .cmdq_pop   (cmdq_pop),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule

`default_nettype wire
